>>> rtl/core/obb_pkg.sv
package obb_pkg;

  localparam int unsigned PosWidthDefault   = 24;
  localparam int unsigned DirFracBitsDefault = 14;

  localparam int unsigned NumAxes   = 4;
  localparam int unsigned NumStages = 6;

endpackage

>>> rtl/core/obb_in_if.sv
interface obb_in_if import obb_pkg::*; #(
  parameter int unsigned POS_WIDTH     = PosWidthDefault,
  parameter int unsigned DIR_FRAC_BITS = DirFracBitsDefault
) ();
  logic                              valid;
  logic                              ready;
  logic signed [POS_WIDTH-1:0]       a_center_x;
  logic signed [POS_WIDTH-1:0]       a_center_y;
  logic        [POS_WIDTH-2:0]       a_half_x;
  logic        [POS_WIDTH-2:0]       a_half_y;
  logic signed [DIR_FRAC_BITS+1:0]   a_dir_x;
  logic signed [DIR_FRAC_BITS+1:0]   a_dir_y;
  logic signed [POS_WIDTH-1:0]       b_center_x;
  logic signed [POS_WIDTH-1:0]       b_center_y;
  logic        [POS_WIDTH-2:0]       b_half_x;
  logic        [POS_WIDTH-2:0]       b_half_y;
  logic signed [DIR_FRAC_BITS+1:0]   b_dir_x;
  logic signed [DIR_FRAC_BITS+1:0]   b_dir_y;

  modport source (
    output valid, a_center_x, a_center_y, a_half_x, a_half_y, a_dir_x, a_dir_y,
           b_center_x, b_center_y, b_half_x, b_half_y, b_dir_x, b_dir_y,
    input  ready
  );
  modport sink (
    input  valid, a_center_x, a_center_y, a_half_x, a_half_y, a_dir_x, a_dir_y,
           b_center_x, b_center_y, b_half_x, b_half_y, b_dir_x, b_dir_y,
    output ready
  );
endinterface

>>> rtl/core/obb_out_if.sv
interface obb_out_if ();
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

>>> rtl/core/obb_dots.sv
module obb_dots import obb_pkg::*; #(
  parameter int unsigned POS_WIDTH     = PosWidthDefault,
  parameter int unsigned DIR_FRAC_BITS = DirFracBitsDefault,
  localparam int unsigned DW  = DIR_FRAC_BITS + 2,
  localparam int unsigned HW  = POS_WIDTH - 1,
  localparam int unsigned AW  = DIR_FRAC_BITS + POS_WIDTH + 2,
  localparam int unsigned MW  = 2 * DIR_FRAC_BITS + 4
) (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  logic signed [POS_WIDTH-1:0] a_cx_i,
  input  logic signed [POS_WIDTH-1:0] a_cy_i,
  input  logic [HW-1:0]        a_hx_i,
  input  logic [HW-1:0]        a_hy_i,
  input  logic signed [DW-1:0] a_rx_i,
  input  logic signed [DW-1:0] a_ry_i,
  input  logic signed [POS_WIDTH-1:0] b_cx_i,
  input  logic signed [POS_WIDTH-1:0] b_cy_i,
  input  logic [HW-1:0]        b_hx_i,
  input  logic [HW-1:0]        b_hy_i,
  input  logic signed [DW-1:0] b_rx_i,
  input  logic signed [DW-1:0] b_ry_i,
  output logic [AW-1:0]        dot_o [NumAxes],
  output logic [MW-1:0]        cc_o,
  output logic [MW-1:0]        cs_o,
  output logic [MW-1:0]        ma_o,
  output logic [MW-1:0]        mb_o,
  output logic [HW-1:0]        a_hx_o,
  output logic [HW-1:0]        a_hy_o,
  output logic [HW-1:0]        b_hx_o,
  output logic [HW-1:0]        b_hy_o
);
  localparam int unsigned CW  = POS_WIDTH + 1;
  localparam int unsigned DPW = DW + CW;
  localparam int unsigned DSW = DPW + 1;
  localparam int unsigned GW  = 2 * DW;
  localparam int unsigned GSW = GW + 1;

  // stage 1: center deltas
  logic signed [CW-1:0] dcx_q, dcy_q;
  logic signed [DW-1:0] rxa1_q, rya1_q, rxb1_q, ryb1_q;
  logic [HW-1:0]        hxa1_q, hya1_q, hxb1_q, hyb1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dcx_q  <= {b_cx_i[POS_WIDTH-1], b_cx_i} - {a_cx_i[POS_WIDTH-1], a_cx_i};
      dcy_q  <= {b_cy_i[POS_WIDTH-1], b_cy_i} - {a_cy_i[POS_WIDTH-1], a_cy_i};
      rxa1_q <= a_rx_i;
      rya1_q <= a_ry_i;
      rxb1_q <= b_rx_i;
      ryb1_q <= b_ry_i;
      hxa1_q <= a_hx_i;
      hya1_q <= a_hy_i;
      hxb1_q <= b_hx_i;
      hyb1_q <= b_hy_i;
    end
  end

  // stage 2: products
  logic signed [DPW-1:0] pd_q [8];
  logic signed [GW-1:0]  pg_q [8];
  logic [HW-1:0]         hxa2_q, hya2_q, hxb2_q, hyb2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pd_q[0] <= rxa1_q * dcx_q;
      pd_q[1] <= rya1_q * dcy_q;
      pd_q[2] <= rxa1_q * dcy_q;
      pd_q[3] <= rya1_q * dcx_q;
      pd_q[4] <= rxb1_q * dcx_q;
      pd_q[5] <= ryb1_q * dcy_q;
      pd_q[6] <= rxb1_q * dcy_q;
      pd_q[7] <= ryb1_q * dcx_q;
      pg_q[0] <= rxa1_q * rxb1_q;
      pg_q[1] <= rya1_q * ryb1_q;
      pg_q[2] <= rya1_q * rxb1_q;
      pg_q[3] <= rxa1_q * ryb1_q;
      pg_q[4] <= rxa1_q * rxa1_q;
      pg_q[5] <= rya1_q * rya1_q;
      pg_q[6] <= rxb1_q * rxb1_q;
      pg_q[7] <= ryb1_q * ryb1_q;
      hxa2_q  <= hxa1_q;
      hya2_q  <= hya1_q;
      hxb2_q  <= hxb1_q;
      hyb2_q  <= hyb1_q;
    end
  end

  // stage 3: sums and magnitudes
  logic signed [DSW-1:0] ds [NumAxes];
  logic signed [DSW-1:0] dabs [NumAxes];
  logic signed [GSW-1:0] cc_s, cs_s, ma_s, mb_s, cc_abs, cs_abs;

  always_comb begin
    ds[0] = DSW'(pd_q[0]) + DSW'(pd_q[1]);
    ds[1] = DSW'(pd_q[2]) - DSW'(pd_q[3]);
    ds[2] = DSW'(pd_q[4]) + DSW'(pd_q[5]);
    ds[3] = DSW'(pd_q[6]) - DSW'(pd_q[7]);
    for (int k = 0; k < NumAxes; k++) begin
      dabs[k] = ds[k][DSW-1] ? -ds[k] : ds[k];
    end
    cc_s   = GSW'(pg_q[0]) + GSW'(pg_q[1]);
    cs_s   = GSW'(pg_q[2]) - GSW'(pg_q[3]);
    ma_s   = GSW'(pg_q[4]) + GSW'(pg_q[5]);
    mb_s   = GSW'(pg_q[6]) + GSW'(pg_q[7]);
    cc_abs = cc_s[GSW-1] ? -cc_s : cc_s;
    cs_abs = cs_s[GSW-1] ? -cs_s : cs_s;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int k = 0; k < NumAxes; k++) begin
        dot_o[k] <= dabs[k][AW-1:0];
      end
      cc_o   <= cc_abs[MW-1:0];
      cs_o   <= cs_abs[MW-1:0];
      ma_o   <= ma_s[MW-1:0];
      mb_o   <= mb_s[MW-1:0];
      a_hx_o <= hxa2_q;
      a_hy_o <= hya2_q;
      b_hx_o <= hxb2_q;
      b_hy_o <= hyb2_q;
    end
  end
endmodule

>>> rtl/core/obb_cmp.sv
module obb_cmp import obb_pkg::*; #(
  parameter int unsigned POS_WIDTH     = PosWidthDefault,
  parameter int unsigned DIR_FRAC_BITS = DirFracBitsDefault,
  localparam int unsigned HW  = POS_WIDTH - 1,
  localparam int unsigned AW  = DIR_FRAC_BITS + POS_WIDTH + 2,
  localparam int unsigned MW  = 2 * DIR_FRAC_BITS + 4
) (
  input  logic          clk_i,
  input  logic [2:0]    en_i,
  input  logic [AW-1:0] dot_i [NumAxes],
  input  logic [MW-1:0] cc_i,
  input  logic [MW-1:0] cs_i,
  input  logic [MW-1:0] ma_i,
  input  logic [MW-1:0] mb_i,
  input  logic [HW-1:0] a_hx_i,
  input  logic [HW-1:0] a_hy_i,
  input  logic [HW-1:0] b_hx_i,
  input  logic [HW-1:0] b_hy_i,
  output logic          overlap_o
);
  localparam int unsigned PRW = MW + HW;
  localparam int unsigned LW  = AW + DIR_FRAC_BITS;
  localparam int unsigned RW  = PRW + 2;

  logic [MW-1:0] mf [NumAxes][3];
  logic [HW-1:0] hf [NumAxes][3];

  // per axis: own extent, then the other box's projected half sizes
  always_comb begin
    mf[0][0] = ma_i; hf[0][0] = a_hx_i;
    mf[0][1] = cc_i; hf[0][1] = b_hx_i;
    mf[0][2] = cs_i; hf[0][2] = b_hy_i;
    mf[1][0] = ma_i; hf[1][0] = a_hy_i;
    mf[1][1] = cs_i; hf[1][1] = b_hx_i;
    mf[1][2] = cc_i; hf[1][2] = b_hy_i;
    mf[2][0] = mb_i; hf[2][0] = b_hx_i;
    mf[2][1] = cc_i; hf[2][1] = a_hx_i;
    mf[2][2] = cs_i; hf[2][2] = a_hy_i;
    mf[3][0] = mb_i; hf[3][0] = b_hy_i;
    mf[3][1] = cs_i; hf[3][1] = a_hx_i;
    mf[3][2] = cc_i; hf[3][2] = a_hy_i;
  end

  // stage 4: extent products
  logic [PRW-1:0] pr_q  [NumAxes][3];
  logic [LW-1:0]  lhs_q [NumAxes];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < NumAxes; k++) begin
        for (int j = 0; j < 3; j++) begin
          pr_q[k][j] <= PRW'(mf[k][j]) * PRW'(hf[k][j]);
        end
        lhs_q[k] <= {dot_i[k], {DIR_FRAC_BITS{1'b0}}};
      end
    end
  end

  // stage 5: total extent
  logic [RW-1:0] rhs_q  [NumAxes];
  logic [LW-1:0] lhs2_q [NumAxes];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int k = 0; k < NumAxes; k++) begin
        rhs_q[k]  <= RW'(pr_q[k][0]) + RW'(pr_q[k][1]) + RW'(pr_q[k][2]);
        lhs2_q[k] <= lhs_q[k];
      end
    end
  end

  // stage 6: strict separation test
  logic [NumAxes-1:0] sep;
  logic               overlap_q;

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      sep[k] = RW'(lhs2_q[k]) > rhs_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      overlap_q <= ~(|sep);
    end
  end

  assign overlap_o = overlap_q;
endmodule

>>> rtl/core/obb_overlap_test_unit.sv
// Oriented box overlap test: each transfer on in_i carries two 2D boxes (center, half sizes,
// direction) and yields one overlap flag on out_o, 1 unless a face of one box has every corner
// of the other strictly in front of it. The arithmetic is exact. The block is a six stage
// pipeline that accepts one pair per cycle unless stalled; each result passes through the stages
// in order to out_o. Stalls collapse bubbles stage by stage, so ready drops
// only when all six stages hold an item and the output is not taken.
module obb_overlap_test_unit import obb_pkg::*; #(
  parameter int unsigned POS_WIDTH     = PosWidthDefault,
  parameter int unsigned DIR_FRAC_BITS = DirFracBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  obb_in_if.sink         in_i,
  obb_out_if.source      out_o
);
  localparam int unsigned HW = POS_WIDTH - 1;
  localparam int unsigned AW = DIR_FRAC_BITS + POS_WIDTH + 2;
  localparam int unsigned MW = 2 * DIR_FRAC_BITS + 4;

  logic [NumStages-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NumStages-1] = ~vld_q[NumStages-1] | out_o.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = ~vld_q[i] | en[i+1];
    end
    vld_d = vld_q;
    if (en[0]) vld_d[0] = in_i.valid;
    for (int i = 1; i < NumStages; i++) begin
      if (en[i]) vld_d[i] = vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = vld_q[NumStages-1];

  logic [AW-1:0] dot [NumAxes];
  logic [MW-1:0] cc, cs, ma, mb;
  logic [HW-1:0] a_hx, a_hy, b_hx, b_hy;

  obb_dots #(
    .POS_WIDTH     (POS_WIDTH),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
  ) u_dots (
    .clk_i  (clk_i),
    .en_i   (en[2:0]),
    .a_cx_i (in_i.a_center_x),
    .a_cy_i (in_i.a_center_y),
    .a_hx_i (in_i.a_half_x),
    .a_hy_i (in_i.a_half_y),
    .a_rx_i (in_i.a_dir_x),
    .a_ry_i (in_i.a_dir_y),
    .b_cx_i (in_i.b_center_x),
    .b_cy_i (in_i.b_center_y),
    .b_hx_i (in_i.b_half_x),
    .b_hy_i (in_i.b_half_y),
    .b_rx_i (in_i.b_dir_x),
    .b_ry_i (in_i.b_dir_y),
    .dot_o  (dot),
    .cc_o   (cc),
    .cs_o   (cs),
    .ma_o   (ma),
    .mb_o   (mb),
    .a_hx_o (a_hx),
    .a_hy_o (a_hy),
    .b_hx_o (b_hx),
    .b_hy_o (b_hy)
  );

  obb_cmp #(
    .POS_WIDTH     (POS_WIDTH),
    .DIR_FRAC_BITS (DIR_FRAC_BITS)
  ) u_cmp (
    .clk_i     (clk_i),
    .en_i      (en[5:3]),
    .dot_i     (dot),
    .cc_i      (cc),
    .cs_i      (cs),
    .ma_i      (ma),
    .mb_i      (mb),
    .a_hx_i    (a_hx),
    .a_hy_i    (a_hy),
    .b_hx_i    (b_hx),
    .b_hy_i    (b_hy),
    .overlap_o (out_o.overlap)
  );

`ifndef ASSERT_OFF
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  a_in_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted transfer did not enter the first stage");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NumStages-2] && en[NumStages-1] |=> vld_q[NumStages-1])
    else $error("item lost before the output stage");
`endif
endmodule
